FILE: src/efi_pkg.sv
// Shared types and register indexes for the escape-time fractal iterator.
// No dependencies.
package efi_pkg;

   localparam int TAG_W = 2;

   localparam logic [7:0] REG_LIMIT  = 8'd0;
   localparam logic [7:0] REG_JULIA  = 8'd1;
   localparam logic [7:0] REG_C_REAL = 8'd2;
   localparam logic [7:0] REG_C_IMAG = 8'd3;

   localparam logic [15:0] LIMIT_RESET  = 16'd256;
   localparam logic [31:0] C_REAL_RESET = 32'hF23D_70A3;
   localparam logic [31:0] C_IMAG_RESET = 32'h03D7_0A3D;

   typedef struct packed {
      logic             valid;
      logic             done;
      logic             escaped;
      logic [TAG_W-1:0] tag;
   } ctl_type;

endpackage

FILE: src/escape_time_fractal_iterate.sv
// Top level of the escape-time fractal iterator: config registers, ring entry
// and in-order retirement. Depends on efi_pkg, efi_square, efi_step, efi_test.
//
//  channel | ports                      | handshake
//  --------+----------------------------+----------------------------
//  request | req_coord_real/imag        | start high, busy low
//  result  | rsp_escape_count/escaped   | rsp_valid strobe, one cycle
//  config  | csr_index, csr_data        | csr_valid and csr_ready
//
// Three points circulate in a three-stage ring (multiply, z*z+c, bound test);
// each pass is one iteration. A point that runs n iterations (set by its escape
// or by the iteration limit) gives its result beat once a part of z reaches
// two, |z|^2 reaches four or the limit stops it, and later while an older
// point still circulates; up to three points are in the ring at once.
// Results leave in arrival order; a finished point keeps circling until older
// ones retire. Reset is synchronous and empties the ring. No stall on output.
module escape_time_fractal_iterate import efi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_coord_real,
   input  logic signed [COORD_WIDTH-1:0] req_coord_imag,
   output logic                          rsp_valid,
   output logic [COUNT_WIDTH-1:0]        rsp_escape_count,
   output logic                          rsp_escaped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [7:0]                    csr_index,
   input  logic [31:0]                   csr_data
);
   localparam int CW = COORD_WIDTH;

   logic [15:0]        limit_ff;
   logic               julia_ff;
   logic signed [31:0] c_real_ff;
   logic signed [31:0] c_imag_ff;
   logic [TAG_W-1:0]   issue_ff, issue_in;
   logic [TAG_W-1:0]   retire_ff, retire_in;

   ctl_type                ctl0, ctl1, ctl2, ctl3;
   logic [COUNT_WIDTH-1:0] cnt0, cnt1, cnt2, cnt3;
   logic signed [CW-1:0]   zr0, zi0, cr0, ci0;
   logic signed [CW-1:0]   cr1, ci1, cr2, ci2, cr3, ci3, zr3, zi3;
   logic signed [2*CW-1:0] xx1, yy1, xy1;
   logic signed [2*CW+1:0] nr2, ni2;
   logic                   retire;
   logic                   accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         julia_ff  <= 1'b0;
         c_real_ff <= C_REAL_RESET;
         c_imag_ff <= C_IMAG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LIMIT:  limit_ff  <= csr_data[15:0];
            REG_JULIA:  julia_ff  <= csr_data[0];
            REG_C_REAL: c_real_ff <= csr_data;
            REG_C_IMAG: c_imag_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // oldest finished point leaves the ring
   assign retire = ctl3.valid && ctl3.done && (ctl3.tag == retire_ff);
   assign busy   = ctl3.valid && !retire;
   assign accept = start && !busy;

   assign issue_in  = accept ? issue_ff + 1'b1 : issue_ff;
   assign retire_in = retire ? retire_ff + 1'b1 : retire_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= '0;
         retire_ff <= '0;
      end else begin
         issue_ff  <= issue_in;
         retire_ff <= retire_in;
      end
   end

   always_comb begin
      ctl0 = ctl3;
      cnt0 = cnt3;
      zr0  = zr3;
      zi0  = zi3;
      cr0  = cr3;
      ci0  = ci3;
      if (accept) begin
         ctl0.valid   = 1'b1;
         ctl0.done    = 1'b0;
         ctl0.escaped = 1'b0;
         ctl0.tag     = issue_ff;
         cnt0         = '0;
         if (julia_ff) begin
            zr0 = req_coord_real;
            zi0 = req_coord_imag;
            cr0 = CW'(c_real_ff);
            ci0 = CW'(c_imag_ff);
         end else begin
            zr0 = '0;
            zi0 = '0;
            cr0 = req_coord_real;
            ci0 = req_coord_imag;
         end
      end else if (retire) begin
         ctl0.valid = 1'b0;
      end
   end

   efi_square #(.COORD_WIDTH(CW), .COUNT_WIDTH(COUNT_WIDTH)) u_square (
      .clock(clock), .reset(reset),
      .ctl_in(ctl0), .cnt_in(cnt0), .zr_in(zr0), .zi_in(zi0),
      .cr_in(cr0), .ci_in(ci0),
      .ctl_ff(ctl1), .cnt_ff(cnt1), .cr_ff(cr1), .ci_ff(ci1),
      .xx_ff(xx1), .yy_ff(yy1), .xy_ff(xy1)
   );

   efi_step #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS),
              .COUNT_WIDTH(COUNT_WIDTH)) u_step (
      .clock(clock), .reset(reset), .limit(COUNT_WIDTH'(limit_ff)),
      .ctl_in(ctl1), .cnt_in(cnt1), .cr_in(cr1), .ci_in(ci1),
      .xx_in(xx1), .yy_in(yy1), .xy_in(xy1),
      .ctl_ff(ctl2), .cnt_ff(cnt2), .cr_ff(cr2), .ci_ff(ci2),
      .nr_ff(nr2), .ni_ff(ni2)
   );

   efi_test #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS),
              .COUNT_WIDTH(COUNT_WIDTH)) u_test (
      .clock(clock), .reset(reset),
      .ctl_in(ctl2), .cnt_in(cnt2), .cr_in(cr2), .ci_in(ci2),
      .nr_in(nr2), .ni_in(ni2),
      .ctl_ff(ctl3), .cnt_ff(cnt3), .cr_ff(cr3), .ci_ff(ci3),
      .zr_ff(zr3), .zi_ff(zi3)
   );

   assign rsp_valid        = retire;
   assign rsp_escape_count = cnt3;
   assign rsp_escaped      = ctl3.escaped;
endmodule

FILE: src/efi_square.sv
// Ring stage 0: the three products of the current z.
// Depends on efi_pkg.
module efi_square import efi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctl_type                         ctl_in,
   input  logic [COUNT_WIDTH-1:0]          cnt_in,
   input  logic signed [COORD_WIDTH-1:0]   zr_in,
   input  logic signed [COORD_WIDTH-1:0]   zi_in,
   input  logic signed [COORD_WIDTH-1:0]   cr_in,
   input  logic signed [COORD_WIDTH-1:0]   ci_in,
   output ctl_type                         ctl_ff,
   output logic [COUNT_WIDTH-1:0]          cnt_ff,
   output logic signed [COORD_WIDTH-1:0]   cr_ff,
   output logic signed [COORD_WIDTH-1:0]   ci_ff,
   output logic signed [2*COORD_WIDTH-1:0] xx_ff,
   output logic signed [2*COORD_WIDTH-1:0] yy_ff,
   output logic signed [2*COORD_WIDTH-1:0] xy_ff
);
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      cnt_ff <= cnt_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      xx_ff  <= zr_in * zr_in;
      yy_ff  <= zi_in * zi_in;
      xy_ff  <= zr_in * zi_in;
   end
endmodule

FILE: src/efi_step.sv
// Ring stage 1: magnitude test of the current z, limit test, new z = z*z + c.
// Depends on efi_pkg.
module efi_step import efi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [COUNT_WIDTH-1:0]          limit,
   input  ctl_type                         ctl_in,
   input  logic [COUNT_WIDTH-1:0]          cnt_in,
   input  logic signed [COORD_WIDTH-1:0]   cr_in,
   input  logic signed [COORD_WIDTH-1:0]   ci_in,
   input  logic signed [2*COORD_WIDTH-1:0] xx_in,
   input  logic signed [2*COORD_WIDTH-1:0] yy_in,
   input  logic signed [2*COORD_WIDTH-1:0] xy_in,
   output ctl_type                         ctl_ff,
   output logic [COUNT_WIDTH-1:0]          cnt_ff,
   output logic signed [COORD_WIDTH-1:0]   cr_ff,
   output logic signed [COORD_WIDTH-1:0]   ci_ff,
   output logic signed [2*COORD_WIDTH+1:0] nr_ff,
   output logic signed [2*COORD_WIDTH+1:0] ni_ff
);
   localparam int MW = 2*COORD_WIDTH + 1;
   localparam int NW = 2*COORD_WIDTH + 2;
   localparam logic signed [MW-1:0] FOUR = MW'(1) <<< (2*FRAC_BITS + 2);

   logic signed [MW-1:0] mag;
   logic signed [MW-1:0] dif;
   logic                 big;
   ctl_type              ctl_in2;
   logic [COUNT_WIDTH-1:0] cnt_in2;

   assign mag = MW'(xx_in) + MW'(yy_in);
   assign dif = MW'(xx_in) - MW'(yy_in);
   assign big = (cnt_in != '0) && (mag >= FOUR);

   always_comb begin
      ctl_in2 = ctl_in;
      cnt_in2 = cnt_in;
      if (ctl_in.valid && !ctl_in.done) begin
         // squares of the last new z reached four: escape at previous index
         if (big) begin
            ctl_in2.done    = 1'b1;
            ctl_in2.escaped = 1'b1;
            cnt_in2         = cnt_in - 1'b1;
         end else if (cnt_in >= limit) begin
            ctl_in2.done = 1'b1;
            cnt_in2      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in2;
      end
      cnt_ff <= cnt_in2;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      nr_ff  <= NW'(dif >>> FRAC_BITS) + NW'(cr_in);
      ni_ff  <= NW'(xy_in >>> (FRAC_BITS - 1)) + NW'(ci_in);
   end
endmodule

FILE: src/efi_test.sv
// Ring stage 2: bound test on the new z and iteration index advance.
// Depends on efi_pkg.
module efi_test import efi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctl_type                         ctl_in,
   input  logic [COUNT_WIDTH-1:0]          cnt_in,
   input  logic signed [COORD_WIDTH-1:0]   cr_in,
   input  logic signed [COORD_WIDTH-1:0]   ci_in,
   input  logic signed [2*COORD_WIDTH+1:0] nr_in,
   input  logic signed [2*COORD_WIDTH+1:0] ni_in,
   output ctl_type                         ctl_ff,
   output logic [COUNT_WIDTH-1:0]          cnt_ff,
   output logic signed [COORD_WIDTH-1:0]   cr_ff,
   output logic signed [COORD_WIDTH-1:0]   ci_ff,
   output logic signed [COORD_WIDTH-1:0]   zr_ff,
   output logic signed [COORD_WIDTH-1:0]   zi_ff
);
   localparam int NW = 2*COORD_WIDTH + 2;
   localparam logic signed [NW-1:0] TWO = NW'(1) <<< (FRAC_BITS + 1);

   logic    out_r;
   logic    out_i;
   ctl_type ctl_in2;
   logic [COUNT_WIDTH-1:0] cnt_in2;

   assign out_r = (nr_in >= TWO) || (nr_in <= -TWO);
   assign out_i = (ni_in >= TWO) || (ni_in <= -TWO);

   always_comb begin
      ctl_in2 = ctl_in;
      cnt_in2 = cnt_in;
      if (ctl_in.valid && !ctl_in.done) begin
         if (out_r || out_i) begin
            ctl_in2.done    = 1'b1;
            ctl_in2.escaped = 1'b1;
         end else begin
            cnt_in2 = cnt_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in2;
      end
      cnt_ff <= cnt_in2;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      zr_ff  <= COORD_WIDTH'(nr_in);
      zi_ff  <= COORD_WIDTH'(ni_in);
   end
endmodule
